// ===== hdl/lcd_scanline_mode_timer_macros.svh =====
// Assertion macros shared by the LCD scanline timer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef LCD_SCANLINE_MODE_TIMER_MACROS_SVH
`define LCD_SCANLINE_MODE_TIMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define LST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/lcdsmt_pkg.sv =====
// Package for the LCD scanline timer: constants, register indexes, mode codes
// and the result beat type. No dependencies.
`timescale 1ns / 1ps

package lcdsmt_pkg;

    localparam int LINE_CYCLES_DEF   = 456;
    localparam int VISIBLE_LINES_DEF = 144;

    localparam int CYCLES_W  = 9;
    localparam int LINE_W    = 8;
    localparam int MODE_W    = 2;
    localparam int ELAPSED_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam int MODE2_CYCLES = 80;
    localparam int MODE3_CYCLES = 172;
    localparam logic [LINE_W-1:0] LAST_LINE   = 8'd153;
    localparam logic [LINE_W-1:0] PARKED_LINE = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OAM_IRQ_EN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COINCIDENCE_IRQ_EN = 3'd5;

    // LCD modes
    localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

    typedef struct packed {
        logic              draw_line;
        logic              vblank_irq;
        logic              stat_irq;
        logic              coincidence_flag;
        logic [MODE_W-1:0] lcd_mode;
        logic [LINE_W-1:0] current_line;
    } t_result;

endpackage

// ===== hdl/lcd_scanline_mode_timer.sv =====
// LCD scanline and mode timer, top level.
// Depends on lcdsmt_pkg and lcd_scanline_mode_timer_macros.svh.
`timescale 1ns / 1ps
`include "lcd_scanline_mode_timer_macros.svh"

// Takes one beat per CPU step carrying its cycle count and returns one status
// beat per step: line counter, LCD mode, coincidence flag and the status,
// vblank and draw requests. One beat is accepted every clock while s_axis_tready
// is high; its result is registered in the output or skid register. Rate is set
// by the single registered update of the countdown/line state, which each step
// reads and rewrites. A two-entry output buffer (output register plus skid
// register) keeps input acceptance going while a result waits; s_axis_tready
// drops only when both are full. Configuration writes take effect at the next
// clock edge and should be made only while no step is in flight.
module lcd_scanline_mode_timer #(
    parameter int LINE_CYCLES   = lcdsmt_pkg::LINE_CYCLES_DEF,
    parameter int VISIBLE_LINES = lcdsmt_pkg::VISIBLE_LINES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [lcdsmt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcdsmt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // step beats
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lcdsmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] elapsed_cycles
    // status beats
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] current_line, [9:8] lcd_mode, [10] coincidence_flag, [11] stat_irq,
    // [12] vblank_irq, [13] draw_line, [15:14] zero
    output logic [lcdsmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import lcdsmt_pkg::*;

    localparam logic [CYCLES_W-1:0] RELOAD     = CYCLES_W'(LINE_CYCLES);
    localparam logic [CYCLES_W-1:0] SCAN_EDGE  = CYCLES_W'(LINE_CYCLES - MODE2_CYCLES);
    localparam logic [CYCLES_W-1:0] XFER_START =
        CYCLES_W'(LINE_CYCLES - MODE2_CYCLES - MODE3_CYCLES);
    localparam logic [LINE_W-1:0]   VIS_LINES  = LINE_W'(VISIBLE_LINES);

    // configuration
    logic              r_display_enable;
    logic [LINE_W-1:0] r_line_compare;
    logic              r_hblank_irq_en;
    logic              r_vblank_irq_en;
    logic              r_oam_irq_en;
    logic              r_coin_irq_en;

    // timing state
    logic [CYCLES_W-1:0] r_cycles_left, n_cycles_left;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic                r_match, n_match;

    // output buffer
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic                 in_accept;
    logic                 out_take;
    logic [ELAPSED_W-1:0] elapsed;
    logic [MODE_W-1:0]    sel_mode;
    logic                 mode_irq_en;
    logic [LINE_W-1:0]    line_inc;

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;
    assign elapsed       = s_axis_tdata[ELAPSED_W-1:0];
    assign line_inc      = r_line + LINE_W'(1);

    always_comb begin
        if (r_line >= VIS_LINES) begin
            sel_mode = MODE_VBLANK;
        end else if (r_cycles_left >= SCAN_EDGE) begin
            sel_mode = MODE_OAM;
        end else if (r_cycles_left >= XFER_START) begin
            sel_mode = MODE_TRANSFER;
        end else begin
            sel_mode = MODE_HBLANK;
        end
    end

    always_comb begin
        case (sel_mode)
            MODE_HBLANK: mode_irq_en = r_hblank_irq_en;
            MODE_VBLANK: mode_irq_en = r_vblank_irq_en;
            MODE_OAM:    mode_irq_en = r_oam_irq_en;
            default:     mode_irq_en = 1'b0;
        endcase
    end

    always_comb begin
        n_cycles_left = r_cycles_left;
        n_line        = r_line;
        n_mode        = r_mode;
        n_match       = r_match;
        n_result      = '0;
        if (!r_display_enable) begin
            // display off holds the timing anchored at the top of the frame
            n_cycles_left = RELOAD;
            n_line        = '0;
            n_mode        = MODE_VBLANK;
        end else begin
            n_mode  = sel_mode;
            n_match = (r_line == r_line_compare);
            n_result.stat_irq = ((sel_mode != r_mode) && mode_irq_en) ||
                                (n_match && r_coin_irq_en);
            if ({1'b0, elapsed} >= r_cycles_left) begin
                // line end: leftover cycles are dropped
                n_cycles_left = RELOAD;
                n_line        = line_inc;
                if (line_inc == VIS_LINES) begin
                    n_result.vblank_irq = 1'b1;
                end else if (line_inc > LAST_LINE) begin
                    n_line = PARKED_LINE;
                end else if (line_inc < VIS_LINES) begin
                    n_result.draw_line = 1'b1;
                end
            end else begin
                n_cycles_left = r_cycles_left - {1'b0, elapsed};
            end
        end
        n_result.current_line     = n_line;
        n_result.lcd_mode         = n_mode;
        n_result.coincidence_flag = n_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable <= 1'b0;
            r_line_compare   <= '0;
            r_hblank_irq_en  <= 1'b0;
            r_vblank_irq_en  <= 1'b0;
            r_oam_irq_en     <= 1'b0;
            r_coin_irq_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DISPLAY_ENABLE:     r_display_enable <= i_cfg_data[0];
                REG_LINE_COMPARE:       r_line_compare   <= i_cfg_data[LINE_W-1:0];
                REG_HBLANK_IRQ_EN:      r_hblank_irq_en  <= i_cfg_data[0];
                REG_VBLANK_IRQ_EN:      r_vblank_irq_en  <= i_cfg_data[0];
                REG_OAM_IRQ_EN:         r_oam_irq_en     <= i_cfg_data[0];
                REG_COINCIDENCE_IRQ_EN: r_coin_irq_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles_left <= RELOAD;
            r_line        <= '0;
            r_mode        <= MODE_HBLANK;
            r_match       <= 1'b0;
        end else if (in_accept) begin
            r_cycles_left <= n_cycles_left;
            r_line        <= n_line;
            r_mode        <= n_mode;
            r_match       <= n_match;
        end
    end

    // output register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_out};

    `LST_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid beat without output beat")
    `LST_ASSERT_IMPL(a_countdown_range, i_clk, i_rst_n, 1'b1,
        (r_cycles_left != '0) && (r_cycles_left <= RELOAD), "line countdown out of range")
    `LST_ASSERT_IMPL(a_line_range, i_clk, i_rst_n, 1'b1,
        (r_line <= LAST_LINE) || (r_line == PARKED_LINE) || (r_line == VIS_LINES),
        "line counter out of range")
    `LST_ASSERT_NEXT(a_display_off_anchor, i_clk, i_rst_n, in_accept && !r_display_enable,
        (r_line == '0) && (r_mode == MODE_VBLANK) && (r_cycles_left == RELOAD),
        "display off did not anchor timing")
    `LST_ASSERT_IMPL(a_vblank_draw_excl, i_clk, i_rst_n, r_out_valid,
        !(r_out.vblank_irq && r_out.draw_line), "vblank and draw requested together")

endmodule

// ===== sim/tb_lcd_scanline_mode_timer.sv =====
// Self-checking testbench for the LCD scanline and mode timer.
// Drives CPU step beats, predicts each status beat and checks it field by field.
// Depends on lcdsmt_pkg and the lcd_scanline_mode_timer RTL.
`timescale 1ns / 1ps

module tb_lcd_scanline_mode_timer;
    import lcdsmt_pkg::*;

    localparam int LINE_CYCLES   = LINE_CYCLES_DEF;
    localparam int VISIBLE_LINES = VISIBLE_LINES_DEF;
    localparam int LONG_HOLD     = 60;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] elapsed_cycles
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] current_line, [9:8] lcd_mode, [10] coincidence_flag, [11] stat_irq,
    // [12] vblank_irq, [13] draw_line, [15:14] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    lcd_scanline_mode_timer #(
        .LINE_CYCLES   (LINE_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Register mirror
    logic             cfg_display_en = 1'b0;
    logic [LINE_W-1:0] cfg_compare   = '0;
    logic             cfg_hblank_en  = 1'b0;
    logic             cfg_vblank_en  = 1'b0;
    logic             cfg_oam_en     = 1'b0;
    logic             cfg_coin_en    = 1'b0;

    // Predicted timer state
    logic [CYCLES_W-1:0] tm_cycles = CYCLES_W'(LINE_CYCLES);
    logic [LINE_W-1:0]   tm_line   = '0;
    logic [MODE_W-1:0]   tm_mode   = MODE_HBLANK;
    logic                tm_match  = 1'b0;

    logic [ELAPSED_W-1:0] step_queue[$];
    t_result              pending_status[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_req       = 0;
    int  hold_seen      = 0;
    int  hold_left      = 0;
    logic step_taken    = 1'b0;
    logic failed        = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("lcd_scanline_mode_timer regression: fail");
        $finish;
    end

    // Status update from the old state, then the countdown
    function automatic t_result advance_lcd_timing(input logic [ELAPSED_W-1:0] elapsed);
        t_result         r;
        logic [MODE_W-1:0] m;
        logic            stat;
        logic            vbl;
        logic            drw;
        stat = 1'b0;
        vbl  = 1'b0;
        drw  = 1'b0;
        if (!cfg_display_en) begin
            tm_cycles = CYCLES_W'(LINE_CYCLES);
            tm_line   = '0;
            tm_mode   = MODE_VBLANK;
        end else begin
            if (tm_line >= VISIBLE_LINES)
                m = MODE_VBLANK;
            else if (tm_cycles >= LINE_CYCLES - MODE2_CYCLES)
                m = MODE_OAM;
            else if (tm_cycles >= LINE_CYCLES - MODE2_CYCLES - MODE3_CYCLES)
                m = MODE_TRANSFER;
            else
                m = MODE_HBLANK;
            if (m != tm_mode) begin
                case (m)
                    MODE_HBLANK: stat = cfg_hblank_en;
                    MODE_VBLANK: stat = cfg_vblank_en;
                    MODE_OAM:    stat = cfg_oam_en;
                    default:     stat = 1'b0;
                endcase
            end
            tm_match = (tm_line == cfg_compare);
            if (tm_match && cfg_coin_en)
                stat = 1'b1;
            tm_mode = m;
            if (elapsed >= tm_cycles) begin
                // leftover cycles are dropped at line end
                tm_line   = tm_line + 1'b1;
                tm_cycles = CYCLES_W'(LINE_CYCLES);
                if (tm_line == VISIBLE_LINES)
                    vbl = 1'b1;
                else if (tm_line > LAST_LINE)
                    tm_line = PARKED_LINE;
                else if (tm_line < VISIBLE_LINES)
                    drw = 1'b1;
            end else begin
                tm_cycles = tm_cycles - elapsed;
            end
        end
        r.current_line     = tm_line;
        r.lcd_mode         = tm_mode;
        r.coincidence_flag = tm_match;
        r.stat_irq         = stat;
        r.vblank_irq       = vbl;
        r.draw_line        = drw;
        return r;
    endfunction

    // Step driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || step_taken) begin
            if (step_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= step_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Status receiver; a long hold-off runs from its own counter
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : status_check
        t_result want;
        t_result got;
        if (i_rst_n) begin
            step_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                pending_status.push_back(advance_lcd_timing(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (pending_status.size() == 0) begin
                    $error("status beat with nothing expected: %h", m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    want = pending_status.pop_front();
                    if (got.current_line !== want.current_line) begin
                        $error("current_line expected %0d got %0d",
                               want.current_line, got.current_line);
                        failed = 1'b1;
                    end
                    if (got.lcd_mode !== want.lcd_mode) begin
                        $error("lcd_mode expected %0d got %0d", want.lcd_mode, got.lcd_mode);
                        failed = 1'b1;
                    end
                    if (got.coincidence_flag !== want.coincidence_flag) begin
                        $error("coincidence_flag expected %0d got %0d",
                               want.coincidence_flag, got.coincidence_flag);
                        failed = 1'b1;
                    end
                    if (got.stat_irq !== want.stat_irq) begin
                        $error("stat_irq expected %0d got %0d", want.stat_irq, got.stat_irq);
                        failed = 1'b1;
                    end
                    if (got.vblank_irq !== want.vblank_irq) begin
                        $error("vblank_irq expected %0d got %0d",
                               want.vblank_irq, got.vblank_irq);
                        failed = 1'b1;
                    end
                    if (got.draw_line !== want.draw_line) begin
                        $error("draw_line expected %0d got %0d",
                               want.draw_line, got.draw_line);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // 1-bit registers get random upper bits; only bit 0 counts
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if (idx != REG_LINE_COMPARE)
            data[CFG_DATA_W-1:1] = (CFG_DATA_W-1)'($urandom);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_DISPLAY_ENABLE:     cfg_display_en = data[0];
            REG_LINE_COMPARE:       cfg_compare    = data;
            REG_HBLANK_IRQ_EN:      cfg_hblank_en  = data[0];
            REG_VBLANK_IRQ_EN:      cfg_vblank_en  = data[0];
            REG_OAM_IRQ_EN:         cfg_oam_en     = data[0];
            REG_COINCIDENCE_IRQ_EN: cfg_coin_en    = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_irq_enables(input int hb, input int vb, input int oam, input int coin);
        write_reg(REG_HBLANK_IRQ_EN, hb);
        write_reg(REG_VBLANK_IRQ_EN, vb);
        write_reg(REG_OAM_IRQ_EN, oam);
        write_reg(REG_COINCIDENCE_IRQ_EN, coin);
    endtask

    // Checked at the rising edge, where the driver's outputs have settled
    task automatic wait_drained();
        while (step_queue.size() != 0 || s_axis_tvalid || pending_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly long steps so frames wrap often, with short ones for mode edges
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return ELAPSED_W'($urandom_range(255, 128));
        else if (r < 80)
            return ELAPSED_W'($urandom_range(40, 0));
        return ELAPSED_W'($urandom_range(255, 0));
    endfunction

    task automatic queue_random_steps(input int n);
        repeat (n) step_queue.push_back(pick_elapsed());
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Display off after reset: anchored timing, mode 1
        step_queue = '{8'd0, 8'd255, 8'd7};
        wait_drained();

        write_reg(REG_UNMAPPED, 8'hFF);
        write_reg(REG_LINE_COMPARE, 0);
        set_irq_enables(1, 1, 1, 1);
        write_reg(REG_DISPLAY_ENABLE, 1);
        // Walk the mode edges of line 0, end it exactly, then with leftovers
        step_queue = '{8'd0, 8'd80, 8'd0, 8'd1, 8'd171, 8'd1, 8'd0, 8'd0,
                       8'd203, 8'd255, 8'd255, 8'd0};
        wait_drained();
        // Display off keeps the coincidence flag
        write_reg(REG_DISPLAY_ENABLE, 0);
        step_queue = '{8'd128, 8'd0};
        wait_drained();
        write_reg(REG_DISPLAY_ENABLE, 1);

        // No idling; compare against the parked line
        write_reg(REG_LINE_COMPARE, 255);
        queue_random_steps(150);
        wait_drained();
        queue_random_steps(200);
        hold_req = hold_req + 1;
        wait_drained();

        send_idle_pct = 63;
        write_reg(REG_LINE_COMPARE, $urandom_range(255));
        set_irq_enables($urandom_range(1), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1));
        queue_random_steps(350);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 63;
        write_reg(REG_LINE_COMPARE, 0);
        set_irq_enables(0, 0, 0, 0);
        queue_random_steps(350);
        wait_drained();

        write_reg(REG_DISPLAY_ENABLE, 0);
        queue_random_steps(20);
        wait_drained();
        write_reg(REG_DISPLAY_ENABLE, 1);

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        write_reg(REG_LINE_COMPARE, VISIBLE_LINES);
        set_irq_enables($urandom_range(1), $urandom_range(1), $urandom_range(1),
                        $urandom_range(1));
        queue_random_steps(350);
        wait_drained();

        if (!failed)
            $display("lcd_scanline_mode_timer regression: pass");
        else
            $display("lcd_scanline_mode_timer regression: fail");
        $finish;
    end

endmodule
